// ===== src/smbp_pkg.sv =====
`timescale 1ns / 1ps

package smbp_pkg;

    localparam int SMBP_TABLE_ENTRIES = 5501;
    localparam int SMBP_HISTORY_BITS  = 13;

    localparam logic [1:0] CTR_MIN     = 2'b00;
    localparam logic [1:0] CTR_MAX     = 2'b11;
    localparam logic [1:0] CTR_WEAK_NT = 2'b01;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REDUCE = 6'b000100,
        S_REMAIN = 6'b001000,
        S_READ   = 6'b010000,
        S_EVAL   = 6'b100000
    } t_state;

    // Two-bit saturating counter moved one step toward the outcome.
    function automatic logic [1:0] ctr_step(input logic [1:0] c, input logic up);
        logic [1:0] r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== src/skewed_majority_branch_predictor.sv =====
`timescale 1ns / 1ps

// Three-bank skewed branch predictor with majority vote.
// A request (i_pc, i_taken) is taken at a rising edge where start is high and
// busy is low. The block hashes the address with its global history into three
// bank indices, reads one 2-bit counter per bank, votes, trains the counters
// and shifts the outcome into the history.
// The result (o_predicted_taken, o_mispredicted) is shown for exactly one
// cycle with o_valid high. Each index is reduced modulo TABLE_ENTRIES by a
// reciprocal multiply for the quotient (S_REDUCE) and a multiply-subtract
// for the remainder (S_REMAIN); S_READ then does the synchronous memory read
// and S_EVAL the read-modify-write, registering the result.
// One request is in flight at a time; busy stays high until its result is
// shown, so a new request is not taken before the last one is through.
// After reset a clearing pass sets every counter to weakly not taken; busy
// stays high meanwhile. The receiver cannot stall.
module skewed_majority_branch_predictor
    import smbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = SMBP_TABLE_ENTRIES,
    parameter int HISTORY_BITS  = SMBP_HISTORY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_pc,
    input  logic        i_taken,
    output logic        o_valid,
    output logic        o_predicted_taken,
    output logic        o_mispredicted
);

    localparam int HB = HISTORY_BITS;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NB = 3;
    localparam int QS = HB + AW;
    localparam int RW = HB + 1;
    localparam int PW = HB + RW;

    localparam longint RECIP_FULL = ((longint'(1) << QS) + longint'(TABLE_ENTRIES)
                                     - longint'(1)) / longint'(TABLE_ENTRIES);
    localparam logic [RW-1:0] RECIP    = RW'(RECIP_FULL);
    localparam logic [HB-1:0] T_H      = HB'(TABLE_ENTRIES);
    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

    function automatic logic [HB-1:0] skew_h(input logic [HB-1:0] m);
        return (m >> 1) | (m ^ {m[0], {(HB - 1){1'b0}}});
    endfunction

    function automatic logic [HB-1:0] skew_i(input logic [HB-1:0] m);
        return {m[HB-2:0], m[0]};
    endfunction

    t_state        r_state, n_state;
    logic [HB-1:0] r_hist, n_hist;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [HB-1:0] r_skew [NB];
    logic [HB-1:0] n_skew [NB];
    logic [HB-1:0] r_quo [NB];
    logic [HB-1:0] n_quo [NB];
    logic [AW-1:0] r_rem [NB];
    logic [AW-1:0] n_rem [NB];
    logic          r_taken, n_taken;
    logic          r_valid, n_valid;
    logic          r_pred, n_pred;
    logic          r_mis, n_mis;
    logic [1:0]    r_rd [NB];

    logic [HB-1:0] pc_m;
    logic [PW-1:0] prod [NB];
    logic [HB-1:0] rem_full [NB];
    logic [NB-1:0] vote;
    logic          pred;
    logic          mis;
    logic [NB-1:0] mem_we;
    logic [AW-1:0] mem_wa [NB];
    logic [1:0]    mem_wd [NB];

    assign pc_m = i_pc[HB-1:0];

    // Majority vote and training decision on the counters read last cycle.
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            vote[b] = r_rd[b][1];
        end
        pred = (vote[0] & vote[1]) | (vote[0] & vote[2]) | (vote[1] & vote[2]);
        mis  = pred ^ r_taken;
    end

    // The rounded-up reciprocal gives the exact quotient for every index value
    // of HISTORY_BITS bits; the remainder is below the table size, so its low
    // address bits are exact even though the subtraction wraps.
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            prod[b]     = PW'(r_skew[b]) * PW'(RECIP);
            rem_full[b] = r_skew[b] - r_quo[b] * T_H;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_hist     = r_hist;
        n_clr_addr = r_clr_addr;
        n_taken    = r_taken;
        n_valid    = 1'b0;
        n_pred     = r_pred;
        n_mis      = r_mis;
        for (int b = 0; b < NB; b++) begin
            n_skew[b] = r_skew[b];
            n_quo[b]  = r_quo[b];
            n_rem[b]  = r_rem[b];
            mem_we[b] = 1'b0;
            mem_wa[b] = r_rem[b];
            mem_wd[b] = ctr_step(r_rd[b], r_taken);
        end
        case (r_state)
            S_CLEAR: begin
                for (int b = 0; b < NB; b++) begin
                    mem_we[b] = 1'b1;
                    mem_wa[b] = r_clr_addr;
                    mem_wd[b] = CTR_WEAK_NT;
                end
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_skew[0] = skew_h(r_hist) ^ skew_i(pc_m) ^ pc_m;
                    n_skew[1] = skew_h(r_hist) ^ skew_i(pc_m) ^ r_hist;
                    n_skew[2] = skew_i(r_hist) ^ skew_h(pc_m) ^ pc_m;
                    for (int b = 0; b < NB; b++) begin
                        n_rem[b] = '0;
                    end
                    n_taken = i_taken;
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                for (int b = 0; b < NB; b++) begin
                    n_quo[b] = HB'(prod[b] >> QS);
                end
                n_state = S_REMAIN;
            end
            S_REMAIN: begin
                for (int b = 0; b < NB; b++) begin
                    n_rem[b] = rem_full[b][AW-1:0];
                end
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // On a correct vote only the agreeing banks train.
                for (int b = 0; b < NB; b++) begin
                    mem_we[b] = mis | (vote[b] == r_taken);
                end
                n_hist  = {r_hist[HB-2:0], r_taken};
                n_valid = 1'b1;
                n_pred  = pred;
                n_mis   = mis;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_hist     <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hist     <= n_hist;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taken <= n_taken;
        r_pred  <= n_pred;
        r_mis   <= n_mis;
        for (int b = 0; b < NB; b++) begin
            r_skew[b] <= n_skew[b];
            r_quo[b]  <= n_quo[b];
            r_rem[b]  <= n_rem[b];
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_bank
        logic [1:0] mem [TABLE_ENTRIES];

        always_ff @(posedge i_clk) begin
            if (mem_we[g]) begin
                mem[mem_wa[g]] <= mem_wd[g];
            end
            if (r_state == S_READ) begin
                r_rd[g] <= mem[r_rem[g]];
            end
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_predicted_taken = r_pred;
    assign o_mispredicted    = r_mis;

endmodule
